// ----- src/pcapd_pkg.sv -----
// Shared types, codes and constants for the pcap record deframer.
`default_nettype none
package pcapd_pkg;

    typedef enum logic [1:0] {
        PH_GLOBAL  = 2'd0,
        PH_RECHDR  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_HALT    = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_BYTE      = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_END_OK    = 3'd2,
        KIND_BAD_MAGIC = 3'd3,
        KIND_SHORT_HDR = 3'd4,
        KIND_BAD_LINK  = 3'd5,
        KIND_TOO_LONG  = 3'd6,
        KIND_TRUNC     = 3'd7
    } t_kind;

    typedef enum logic {
        CFG_LINK_TYPE = 1'b0,
        CFG_MAX_LEN   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  frame_byte;
        logic [24:0] record_length;
        logic [23:0] byte_index;
        logic        last_of_record;
        logic [63:0] timestamp_ms;
    } t_out_beat;

    localparam logic [31:0] MAGIC_US_SWAP = 32'hD4C3B2A1;
    localparam logic [31:0] MAGIC_NS_SWAP = 32'h4D3CB2A1;
    localparam logic [31:0] MAGIC_US      = 32'hA1B2C3D4;
    localparam logic [31:0] MAGIC_NS      = 32'hA1B23C4D;

    localparam logic [24:0] LEN_CEILING    = 25'd16777216;
    localparam logic [31:0] LINK_TYPE_RST  = 32'd227;

    // header byte positions (count before the beat is taken)
    localparam logic [4:0] GHDR_MAGIC_LAST = 5'd3;
    localparam logic [4:0] GHDR_LAST       = 5'd23;
    localparam logic [4:0] RHDR_SEC_LAST   = 5'd3;
    localparam logic [4:0] RHDR_FRAC_LAST  = 5'd7;
    localparam logic [4:0] RHDR_WORDS_END  = 5'd12;
    localparam logic [4:0] RHDR_LAST       = 5'd15;

    // fraction to ms: multiply by a rounded-up reciprocal, then shift
    localparam logic [30:0] RECIP_US = 31'd274877907;   // ceil(2^38 / 1000)
    localparam int          SHIFT_US = 38;
    localparam logic [30:0] RECIP_NS = 31'd1125899907;  // ceil(2^50 / 1000000)
    localparam int          SHIFT_NS = 50;
    localparam logic [9:0]  MS_PER_S = 10'd1000;

    function automatic logic [31:0] order_word(input logic [31:0] w, input logic swap);
        order_word = swap ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
    endfunction

endpackage
`default_nettype wire

// ----- src/pcapd_time.sv -----
// Record time in ms from the seconds and fraction fields, two register stages.
`default_nettype none
module pcapd_time (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_seconds,
    input  wire logic [31:0] i_fraction,
    input  wire logic        i_nano,
    output logic      [63:0] o_record_time
);
    import pcapd_pkg::*;

    logic [41:0] r_sec_ms;
    logic [62:0] r_frac_prod;
    logic        r_nano;
    logic [63:0] r_time;
    logic [30:0] recip;
    logic [22:0] frac_ms;

    assign recip = i_nano ? RECIP_NS : RECIP_US;

    always_ff @(posedge i_clk) begin
        r_sec_ms    <= 42'(i_seconds) * 42'(MS_PER_S);
        r_frac_prod <= 63'(i_fraction) * 63'(recip);
        r_nano      <= i_nano;
        r_time      <= 64'(r_sec_ms) + 64'(frac_ms);
    end

    assign frac_ms = r_nano ? 23'(r_frac_prod >> SHIFT_NS) : 23'(r_frac_prod >> SHIFT_US);
    assign o_record_time = r_time;

endmodule
`default_nettype wire

// ----- src/pcap_record_deframer.sv -----
// Top level: classic pcap stream deframer, one file byte per beat.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one file byte
// per beat, or an end-of-file marker when func is set. Output channel
// (o_out_valid / i_out_stall / o_out_data) carries at most one result beat
// per input beat: a payload byte with its record length, index, last flag
// and relative ms timestamp, an empty-record note, or an end / error status.
// The result is registered and appears in the cycle after its input beat;
// one input beat is taken every cycle, limited only by the single output
// register. The record time is built by a two-stage multiply unit that
// runs while the header length words stream in, so no bubble is needed.
// Config is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data): index 0
// is the expected link type, index 1 the largest accepted record length.
// Reset (synchronous, active low) returns to the global header phase and
// loads link type 227 and max length 2^24. When the receiver stalls with a
// result held, o_in_stall rises and the held beat stays unchanged.
// An error (bad magic, bad link, oversized record) drops bytes until the
// end-of-file beat, which always returns the parser to its start state.
`default_nettype none
module pcap_record_deframer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire pcapd_pkg::t_in_beat   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output pcapd_pkg::t_out_beat       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);
    import pcapd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hcnt, n_hcnt;
    logic [31:0] r_magic, n_magic;
    logic        r_swap, n_swap;
    logic        r_nano, n_nano;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_sec, n_sec;
    logic [31:0] r_frac, n_frac;
    logic [24:0] r_len, n_len;
    logic [23:0] r_done, n_done;
    logic [63:0] r_first, n_first;
    logic [63:0] r_rel, n_rel;

    logic [31:0] r_link_cfg;
    logic [24:0] r_max_cfg;

    logic        r_out_valid;
    t_out_beat   r_out;
    t_out_beat   n_beat;
    logic        emit;

    logic        accept;
    logic [63:0] record_time;
    logic [31:0] acc_new;
    logic [1:0]  pos;
    logic [31:0] incl;
    logic [24:0] limit;
    logic        last;

    pcapd_time u_time (
        .i_clk         (i_clk),
        .i_seconds     (r_sec),
        .i_fraction    (r_frac),
        .i_nano        (r_nano),
        .o_record_time (record_time)
    );

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pos     = r_hcnt[1:0];
    assign acc_new = ((pos == 2'd0) ? 32'd0 : r_acc)
                   | (32'(i_in_data.data_byte) << {pos, 3'b000});
    assign incl    = order_word(r_acc, r_swap);
    assign limit   = (r_max_cfg < LEN_CEILING) ? r_max_cfg : LEN_CEILING;
    assign last    = (({1'b0, r_done} + 25'd1) == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_cfg <= LINK_TYPE_RST;
            r_max_cfg  <= LEN_CEILING;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LINK_TYPE: r_link_cfg <= i_cfg_data;
                CFG_MAX_LEN:   r_max_cfg  <= i_cfg_data[24:0];
                default:       r_link_cfg <= r_link_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GLOBAL;
            r_hcnt  <= '0;
            r_magic <= '0;
            r_swap  <= 1'b0;
            r_nano  <= 1'b0;
            r_acc   <= '0;
            r_sec   <= '0;
            r_frac  <= '0;
            r_len   <= '0;
            r_done  <= '0;
            r_first <= '0;
            r_rel   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_magic <= n_magic;
            r_swap  <= n_swap;
            r_nano  <= n_nano;
            r_acc   <= n_acc;
            r_sec   <= n_sec;
            r_frac  <= n_frac;
            r_len   <= n_len;
            r_done  <= n_done;
            r_first <= n_first;
            r_rel   <= n_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= n_beat;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_magic = r_magic;
        n_swap  = r_swap;
        n_nano  = r_nano;
        n_acc   = r_acc;
        n_sec   = r_sec;
        n_frac  = r_frac;
        n_len   = r_len;
        n_done  = r_done;
        n_first = r_first;
        n_rel   = r_rel;
        emit    = 1'b0;
        n_beat  = '0;

        if (accept) begin
            if (i_in_data.func) begin
                case (r_phase)
                    PH_GLOBAL: begin
                        emit        = 1'b1;
                        n_beat.kind = KIND_SHORT_HDR;
                    end
                    PH_RECHDR: begin
                        emit        = 1'b1;
                        n_beat.kind = KIND_END_OK;
                    end
                    PH_PAYLOAD: begin
                        emit                 = 1'b1;
                        n_beat.kind          = KIND_TRUNC;
                        n_beat.record_length = r_len;
                        n_beat.byte_index    = r_done;
                        n_beat.timestamp_ms  = r_rel;
                    end
                    default: emit = 1'b0;
                endcase
                n_phase = PH_GLOBAL;
                n_hcnt  = '0;
                n_magic = '0;
                n_swap  = 1'b0;
                n_nano  = 1'b0;
                n_acc   = '0;
                n_sec   = '0;
                n_frac  = '0;
                n_len   = '0;
                n_done  = '0;
                n_first = '0;
                n_rel   = '0;
            end else begin
                case (r_phase)
                    PH_PAYLOAD: begin
                        emit                  = 1'b1;
                        n_beat.kind           = KIND_BYTE;
                        n_beat.frame_byte     = i_in_data.data_byte;
                        n_beat.record_length  = r_len;
                        n_beat.byte_index     = r_done;
                        n_beat.last_of_record = last;
                        n_beat.timestamp_ms   = r_rel;
                        if (last) begin
                            n_phase = PH_RECHDR;
                            n_hcnt  = '0;
                            n_done  = '0;
                        end else begin
                            n_done = r_done + 24'd1;
                        end
                    end
                    PH_GLOBAL: begin
                        n_acc  = acc_new;
                        n_hcnt = r_hcnt + 5'd1;
                        if (r_hcnt == GHDR_MAGIC_LAST) begin
                            n_magic = acc_new;
                            n_swap  = (acc_new == MAGIC_US_SWAP) || (acc_new == MAGIC_NS_SWAP);
                            n_nano  = (acc_new == MAGIC_NS) || (acc_new == MAGIC_NS_SWAP);
                        end
                        if (r_hcnt == GHDR_LAST) begin
                            if (!(r_magic inside {MAGIC_US_SWAP, MAGIC_NS_SWAP,
                                                  MAGIC_US, MAGIC_NS})) begin
                                emit        = 1'b1;
                                n_beat.kind = KIND_BAD_MAGIC;
                                n_phase     = PH_HALT;
                            end else if (order_word(acc_new, r_swap) != r_link_cfg) begin
                                emit        = 1'b1;
                                n_beat.kind = KIND_BAD_LINK;
                                n_phase     = PH_HALT;
                            end else begin
                                n_phase = PH_RECHDR;
                                n_hcnt  = '0;
                            end
                        end
                    end
                    PH_RECHDR: begin
                        if (r_hcnt < RHDR_WORDS_END) begin
                            n_acc = acc_new;
                            if (r_hcnt == RHDR_SEC_LAST) begin
                                n_sec = order_word(acc_new, r_swap);
                            end
                            if (r_hcnt == RHDR_FRAC_LAST) begin
                                n_frac = order_word(acc_new, r_swap);
                            end
                        end
                        n_hcnt = r_hcnt + 5'd1;
                        if (r_hcnt == RHDR_LAST) begin
                            n_hcnt = '0;
                            if (incl > 32'(limit)) begin
                                emit        = 1'b1;
                                n_beat.kind = KIND_TOO_LONG;
                                n_phase     = PH_HALT;
                            end else begin
                                // first non-zero record time becomes the origin
                                if (r_first == 64'd0) begin
                                    n_first = record_time;
                                    n_rel   = 64'd0;
                                end else begin
                                    n_rel = record_time - r_first;
                                end
                                n_len  = incl[24:0];
                                n_done = '0;
                                if (incl == 32'd0) begin
                                    emit                  = 1'b1;
                                    n_beat.kind           = KIND_EMPTY;
                                    n_beat.last_of_record = 1'b1;
                                    n_beat.timestamp_ms   = n_rel;
                                end else begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    default: emit = 1'b0;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ----- dv/pcap_record_deframer_tb.sv -----
// Testbench for pcap_record_deframer: pcap byte streams checked against a local deframe model.
`timescale 1ns / 100ps
module pcap_record_deframer_tb;
    import pcapd_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    t_in_beat     in_beat = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    t_out_beat    out_beat;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_data = '0;

    pcap_record_deframer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // deframe model state
    t_phase       ph = PH_GLOBAL;
    logic [4:0]   hdr_cnt = '0;
    logic [31:0]  magic = '0;
    logic         swapped = 1'b0;
    logic         nano = 1'b0;
    logic [31:0]  acc = '0;
    logic [31:0]  sec_word = '0;
    logic [31:0]  frac_word = '0;
    logic [24:0]  rec_len = '0;
    logic [23:0]  rec_pos = '0;
    logic [63:0]  rec_ms = '0;
    logic [63:0]  base_ms = '0;
    logic [31:0]  cfg_link = LINK_TYPE_RST;
    logic [24:0]  cfg_max_len = LEN_CEILING;

    t_out_beat    due_results[$];
    int           errors = 0;
    int           beats_sent = 0;
    int           results_seen = 0;
    int           files_sent = 0;
    int           burst_left = 0;
    logic         no_gaps = 1'b0;
    logic         hold_req = 1'b0;
    logic         file_swap = 1'b0;

    logic [31:0]  good_magic [4] = '{MAGIC_US, MAGIC_NS, MAGIC_US_SWAP, MAGIC_NS_SWAP};

    function automatic logic [31:0] host_word(input logic [31:0] w, input logic sw);
        return sw ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
    endfunction

    function automatic logic [31:0] gather(input logic [31:0] w, input logic [1:0] pos,
                                           input logic [7:0] b);
        return (pos == 2'd0 ? 32'd0 : w) | ({24'd0, b} << (8 * pos));
    endfunction

    task automatic deframe_step(input t_in_beat b);
        t_out_beat    r;
        logic [31:0]  incl;
        logic [24:0]  lim;
        r = '0;
        if (b.func) begin
            case (ph)
                PH_GLOBAL: begin
                    r.kind = KIND_SHORT_HDR;
                    due_results.push_back(r);
                end
                PH_RECHDR: begin
                    r.kind = KIND_END_OK;
                    due_results.push_back(r);
                end
                PH_PAYLOAD: begin
                    r.kind = KIND_TRUNC;
                    r.record_length = rec_len;
                    r.byte_index = rec_pos;
                    r.timestamp_ms = rec_ms - base_ms;
                    due_results.push_back(r);
                end
                default: ;
            endcase
            ph = PH_GLOBAL;
            hdr_cnt = '0;
            magic = '0;
            swapped = 1'b0;
            nano = 1'b0;
            acc = '0;
            sec_word = '0;
            frac_word = '0;
            rec_len = '0;
            rec_pos = '0;
            rec_ms = '0;
            base_ms = '0;
        end else if (ph == PH_PAYLOAD) begin
            r.kind = KIND_BYTE;
            r.frame_byte = b.data_byte;
            r.record_length = rec_len;
            r.byte_index = rec_pos;
            r.last_of_record = ({1'b0, rec_pos} + 25'd1 == rec_len);
            r.timestamp_ms = rec_ms - base_ms;
            due_results.push_back(r);
            if (r.last_of_record) begin
                ph = PH_RECHDR;
                hdr_cnt = '0;
                rec_pos = '0;
            end else begin
                rec_pos = rec_pos + 24'd1;
            end
        end else if (ph == PH_GLOBAL) begin
            acc = gather(acc, hdr_cnt[1:0], b.data_byte);
            hdr_cnt = hdr_cnt + 5'd1;
            if (hdr_cnt == 5'd4) begin
                magic = acc;
                swapped = (magic == MAGIC_US_SWAP) || (magic == MAGIC_NS_SWAP);
                nano = (magic == MAGIC_NS) || (magic == MAGIC_NS_SWAP);
            end
            if (hdr_cnt == 5'd24) begin
                if (magic != MAGIC_US && magic != MAGIC_NS &&
                    magic != MAGIC_US_SWAP && magic != MAGIC_NS_SWAP) begin
                    r.kind = KIND_BAD_MAGIC;
                    due_results.push_back(r);
                    ph = PH_HALT;
                end else if (host_word(acc, swapped) != cfg_link) begin
                    r.kind = KIND_BAD_LINK;
                    due_results.push_back(r);
                    ph = PH_HALT;
                end else begin
                    ph = PH_RECHDR;
                    hdr_cnt = '0;
                end
            end
        end else if (ph == PH_RECHDR) begin
            // original length (bytes 12..15) is not collected
            if (hdr_cnt < 5'd12) begin
                acc = gather(acc, hdr_cnt[1:0], b.data_byte);
                if (hdr_cnt == 5'd3)
                    sec_word = host_word(acc, swapped);
                else if (hdr_cnt == 5'd7)
                    frac_word = host_word(acc, swapped);
            end
            hdr_cnt = hdr_cnt + 5'd1;
            if (hdr_cnt == 5'd16) begin
                incl = host_word(acc, swapped);
                lim = (cfg_max_len < LEN_CEILING) ? cfg_max_len : LEN_CEILING;
                hdr_cnt = '0;
                if (incl > {7'd0, lim}) begin
                    r.kind = KIND_TOO_LONG;
                    due_results.push_back(r);
                    ph = PH_HALT;
                end else begin
                    rec_ms = {32'd0, sec_word} * 64'd1000 +
                             {32'd0, frac_word / (nano ? 32'd1000000 : 32'd1000)};
                    // base is latched from the first record with a non-zero ms time
                    if (base_ms == 64'd0)
                        base_ms = rec_ms;
                    rec_len = incl[24:0];
                    rec_pos = '0;
                    if (incl == 32'd0) begin
                        r.kind = KIND_EMPTY;
                        r.last_of_record = 1'b1;
                        r.timestamp_ms = rec_ms - base_ms;
                        due_results.push_back(r);
                    end else begin
                        ph = PH_PAYLOAD;
                    end
                end
            end
        end
    endtask

    // accepted beats feed the model before results are checked, so a result still finds its entry
    always @(posedge clk) begin : monitor
        t_out_beat want;
        if (rst_n) begin
            if (in_valid && !in_stall)
                deframe_step(in_beat);
            if (out_valid && !out_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("unexpected result beat, kind %0d", out_beat.kind);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    if (out_beat.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, out_beat.kind);
                        errors++;
                    end
                    if (out_beat.frame_byte !== want.frame_byte) begin
                        $error("frame_byte: expected %0h, got %0h",
                               want.frame_byte, out_beat.frame_byte);
                        errors++;
                    end
                    if (out_beat.record_length !== want.record_length) begin
                        $error("record_length: expected %0d, got %0d",
                               want.record_length, out_beat.record_length);
                        errors++;
                    end
                    if (out_beat.byte_index !== want.byte_index) begin
                        $error("byte_index: expected %0d, got %0d",
                               want.byte_index, out_beat.byte_index);
                        errors++;
                    end
                    if (out_beat.last_of_record !== want.last_of_record) begin
                        $error("last_of_record: expected %0b, got %0b",
                               want.last_of_record, out_beat.last_of_record);
                        errors++;
                    end
                    if (out_beat.timestamp_ms !== want.timestamp_ms) begin
                        $error("timestamp_ms: expected %0h, got %0h",
                               want.timestamp_ms, out_beat.timestamp_ms);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver: random stall modes, plus a long hold on request
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_tick = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            stall_tick++;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((stall_tick % 5) < 2);
                endcase
            end
        end
    end

    task automatic send_beat(input logic func, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_beat <= {func, data};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        beats_sent++;
    endtask

    task automatic send_eof();
        send_beat(1'b1, 8'($urandom_range(0, 255)));
        files_sent++;
    endtask

    task automatic send_word(input logic [31:0] w, input logic sw);
        if (sw) begin
            send_beat(1'b0, w[31:24]);
            send_beat(1'b0, w[23:16]);
            send_beat(1'b0, w[15:8]);
            send_beat(1'b0, w[7:0]);
        end else begin
            send_beat(1'b0, w[7:0]);
            send_beat(1'b0, w[15:8]);
            send_beat(1'b0, w[23:16]);
            send_beat(1'b0, w[31:24]);
        end
    endtask

    // magic, version, zone, sigfigs, snaplen, link type
    task automatic send_global(input logic [31:0] mg, input logic [31:0] link);
        file_swap = (mg == MAGIC_US_SWAP) || (mg == MAGIC_NS_SWAP);
        send_word(mg, 1'b0);
        repeat (4) send_word($urandom, file_swap);
        send_word(link, file_swap);
    endtask

    task automatic send_record(input logic [31:0] sec, input logic [31:0] frac,
                               input logic [31:0] incl, input int nbytes);
        send_word(sec, file_swap);
        send_word(frac, file_swap);
        send_word(incl, file_swap);
        send_word($urandom, file_swap);
        repeat (nbytes) send_beat(1'b0, 8'($urandom_range(0, 255)));
    endtask

    // the input goes idle before the queue is checked, so the monitor has taken the last accepted beat
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LINK_TYPE)
            cfg_link = val;
        else
            cfg_max_len = val[24:0];
        @(posedge clk);
    endtask

    task automatic test_header_errors();
        send_eof();
        repeat (23) send_beat(1'b0, 8'($urandom_range(0, 255)));
        send_eof();
        send_global(32'h12345678, cfg_link);
        repeat (5) send_beat(1'b0, 8'($urandom_range(0, 255)));
        send_eof();
        send_global(MAGIC_US, cfg_link ^ 32'd1);
        repeat (3) send_beat(1'b0, 8'($urandom_range(0, 255)));
        send_eof();
        drain();
    endtask

    task automatic test_magic_orders();
        for (int i = 0; i < 4; i++) begin
            send_global(good_magic[i], cfg_link);
            send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 2);
            send_record(32'd1, 32'd999_999_999, 32'd1, 1);
            send_eof();
        end
        drain();
    endtask

    task automatic test_first_timestamp();
        send_global(MAGIC_US, cfg_link);
        send_record(32'd0, 32'd999, 32'd1, 1);
        send_record(32'd0, 32'd0, 32'd0, 0);
        send_record(32'd2, 32'd5000, 32'd2, 2);
        // earlier than the base: relative time wraps
        send_record(32'd1, 32'd0, 32'd0, 0);
        send_record(32'd3, 32'd0, 32'd3, 1);
        send_eof();
        send_global(MAGIC_NS_SWAP, cfg_link);
        send_record(32'd5, 32'd0, 32'd1, 1);
        repeat (7) send_beat(1'b0, 8'($urandom_range(0, 255)));
        send_eof();
        drain();
    endtask

    task automatic test_length_limits();
        write_reg(CFG_MAX_LEN, 32'd0);
        send_global(MAGIC_US, cfg_link);
        send_record(32'd1, 32'd0, 32'd0, 0);
        send_record(32'd1, 32'd0, 32'd1, 1);
        send_eof();
        drain();
        write_reg(CFG_MAX_LEN, 32'd3);
        send_global(MAGIC_NS, cfg_link);
        send_record(32'd7, 32'd0, 32'd3, 3);
        send_record(32'd8, 32'd0, 32'd4, 2);
        send_eof();
        drain();
        // register above the ceiling: the ceiling still applies
        write_reg(CFG_MAX_LEN, 32'h01FF_FFFF);
        send_global(MAGIC_US_SWAP, cfg_link);
        send_record(32'd1, 32'd0, 32'h0100_0001, 2);
        send_eof();
        send_global(MAGIC_US, cfg_link);
        send_record(32'd1, 32'd0, 32'hFFFF_FFFF, 0);
        send_eof();
        send_global(MAGIC_US, cfg_link);
        send_record(32'd9, 32'd0, {7'd0, LEN_CEILING}, 5);
        send_eof();
        drain();
        write_reg(CFG_MAX_LEN, {7'd0, LEN_CEILING});
    endtask

    task automatic test_link_register();
        logic [31:0] link;
        write_reg(CFG_LINK_TYPE, 32'd0);
        send_global(MAGIC_NS, 32'd0);
        send_record(32'd4, 32'd2_000_000, 32'd2, 2);
        send_eof();
        send_global(MAGIC_NS, LINK_TYPE_RST);
        send_eof();
        drain();
        write_reg(CFG_LINK_TYPE, 32'hFFFF_FFFF);
        send_global(MAGIC_NS_SWAP, 32'hFFFF_FFFF);
        send_record(32'd4, 32'd0, 32'd1, 1);
        send_eof();
        drain();
        link = $urandom;
        write_reg(CFG_LINK_TYPE, link);
        send_global(MAGIC_US_SWAP, link);
        send_record($urandom, $urandom, 32'd2, 2);
        send_eof();
        drain();
        write_reg(CFG_LINK_TYPE, LINK_TYPE_RST);
    endtask

    // output held for a long stretch while the input offers beats with no gaps
    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_req = 1'b1;
        send_global(MAGIC_US, cfg_link);
        send_record(32'd10, 32'd1000, 32'd60, 60);
        send_record(32'd11, 32'd1000, 32'd20, 20);
        send_eof();
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_random_files();
        int          stop_at;
        int          nrec;
        int          c;
        int          nbytes;
        logic [31:0] mg;
        logic [31:0] link;
        logic [31:0] sec;
        logic [31:0] frac;
        logic [31:0] incl;
        stop_at = beats_sent + 450;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                drain();
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(CFG_LINK_TYPE,
                              ($urandom_range(0, 2) == 0) ? $urandom : LINK_TYPE_RST);
                end else begin
                    case ($urandom_range(0, 3))
                        0: write_reg(CFG_MAX_LEN, $urandom_range(0, 8));
                        1: write_reg(CFG_MAX_LEN, {7'd0, LEN_CEILING});
                        2: write_reg(CFG_MAX_LEN, 32'h01FF_FFFF);
                        default: write_reg(CFG_MAX_LEN, $urandom_range(9, 40));
                    endcase
                end
            end
            if ($urandom_range(0, 99) < 6) begin
                // noise: junk bytes, most likely a bad magic or a short header
                repeat ($urandom_range(1, 30)) send_beat(1'b0, 8'($urandom_range(0, 255)));
                send_eof();
            end else begin
                mg = ($urandom_range(0, 99) < 8) ? $urandom
                                                 : good_magic[2'($urandom_range(0, 3))];
                link = ($urandom_range(0, 9) == 0) ? $urandom : cfg_link;
                send_global(mg, link);
                nrec = $urandom_range(0, 5);
                for (int k = 0; k < nrec; k++) begin
                    c = $urandom_range(0, 19);
                    if (c < 13)
                        incl = $urandom_range(0, 6);
                    else if (c < 17)
                        incl = $urandom_range(7, 30);
                    else if (c == 17)
                        incl = {7'd0, LEN_CEILING} + 32'd1 + $urandom_range(0, 1000);
                    else if (c == 18)
                        incl = $urandom;
                    else
                        incl = 32'd0;
                    nbytes = (incl <= 32'd30) ? int'(incl) : 3;
                    case ($urandom_range(0, 2))
                        0: sec = 32'd0;
                        1: sec = $urandom_range(0, 100);
                        default: sec = $urandom;
                    endcase
                    frac = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 999_999);
                    send_record(sec, frac, incl, nbytes);
                end
                c = $urandom_range(0, 9);
                if (c == 0)
                    repeat ($urandom_range(1, 15)) send_beat(1'b0, 8'($urandom_range(0, 255)));
                else if (c == 1)
                    send_record($urandom, $urandom, 32'd10, $urandom_range(0, 9));
                send_eof();
            end
        end
        drain();
    endtask

    initial begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_errors();
        test_magic_orders();
        test_first_timestamp();
        test_length_limits();
        test_link_register();
        test_backpressure();
        test_random_files();
        $display("Sent %0d beats in %0d files; checked %0d result beats.",
                 beats_sent, files_sent, results_seen);
        $display("Covered all four magic orders, header and length errors, empty,"
                 , " truncated and wrapped-time records, and a long output hold.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
